// ===== hw/rtl/lob_pkg.sv =====
`timescale 1ns / 1ps
package lob_pkg;

	localparam int unsigned MAX_ORDERS_DEF = 32;
	localparam int unsigned DW = 32;
	localparam int unsigned TVW = 31;

	typedef enum logic [1:0] {
		REQ_PLACE  = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_MODIFY = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_SUCCESS  = 3'd0,
		ST_PARTIAL  = 3'd1,
		ST_COMPLETE = 3'd2,
		ST_INVALID  = 3'd3,
		ST_DUP      = 3'd4,
		ST_NOTFOUND = 3'd5,
		ST_FULL     = 3'd6
	} stat_t;

	typedef enum logic [1:0] {
		SM_FIND  = 2'd0,
		SM_MATCH = 2'd1,
		SM_FREE  = 2'd2,
		SM_BEST  = 2'd3
	} scan_mode_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       scan_start;
		logic       scan_step;
		scan_mode_t mode;
		logic       kill;
		logic       shrink;
		logic       side_from_hit;
		logic       do_trade;
		logic       rest;
		logic       emit_trade;
		logic       emit_status;
		stat_t      stat;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic hit;
		logic shrink_ok;
		logic req_bad;
		logic fill_done;
		logic partial;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/lob_ctrl.sv =====
`timescale 1ns / 1ps
module lob_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       req_type,
	input  lob_pkg::sts_t    sts,
	output lob_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_FIND, S_FDEC, S_MATCH, S_MDEC, S_TRADE,
		S_FREE, S_REST, S_BEST, S_STAT
	} state_t;

	state_t          state_q;
	lob_pkg::req_t   type_q;
	lob_pkg::stat_t  stat_q;
	logic            report_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.stat = stat_q;
		cmd.mode = lob_pkg::SM_FIND;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_CHECK: cmd.scan_start = 1'b1;
			S_FIND: begin
				cmd.mode = lob_pkg::SM_FIND;
				cmd.scan_step = 1'b1;
			end
			S_FDEC: begin
				cmd.scan_start = 1'b1;
				if (type_q == lob_pkg::REQ_CANCEL) begin
					cmd.kill = sts.hit;
				end else if (type_q == lob_pkg::REQ_MODIFY && sts.hit) begin
					cmd.shrink = sts.shrink_ok;
					cmd.kill = !sts.shrink_ok;
					cmd.side_from_hit = !sts.shrink_ok;
				end
			end
			S_MATCH: begin
				cmd.mode = lob_pkg::SM_MATCH;
				cmd.scan_step = 1'b1;
			end
			S_MDEC: cmd.scan_start = 1'b1;
			S_TRADE: begin
				if (!report_q || sts.out_free) begin
					cmd.do_trade = 1'b1;
					cmd.emit_trade = report_q;
					cmd.scan_start = 1'b1;
				end
			end
			S_FREE: begin
				cmd.mode = lob_pkg::SM_FREE;
				cmd.scan_step = 1'b1;
			end
			S_REST: begin
				cmd.rest = sts.hit;
				cmd.scan_start = 1'b1;
			end
			S_BEST: begin
				cmd.mode = lob_pkg::SM_BEST;
				cmd.scan_step = 1'b1;
			end
			S_STAT: cmd.emit_status = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			type_q   <= lob_pkg::REQ_PLACE;
			stat_q   <= lob_pkg::ST_SUCCESS;
			report_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						type_q   <= lob_pkg::req_t'(req_type);
						report_q <= 1'b1;
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (type_q == lob_pkg::REQ_NONE ||
					    (type_q == lob_pkg::REQ_PLACE && sts.req_bad)) begin
						stat_q  <= lob_pkg::ST_INVALID;
						state_q <= S_BEST;
					end else begin
						state_q <= S_FIND;
					end
				end
				S_FIND: if (sts.scan_last) state_q <= S_FDEC;
				S_FDEC: begin
					state_q <= S_BEST;
					case (type_q)
						lob_pkg::REQ_PLACE: begin
							if (sts.hit) stat_q <= lob_pkg::ST_DUP;
							else state_q <= S_MATCH;
						end
						lob_pkg::REQ_CANCEL: begin
							stat_q <= sts.hit ? lob_pkg::ST_SUCCESS : lob_pkg::ST_NOTFOUND;
						end
						default: begin
							if (!sts.hit) begin
								stat_q <= lob_pkg::ST_NOTFOUND;
							end else if (sts.shrink_ok) begin
								stat_q <= lob_pkg::ST_SUCCESS;
							end else begin
								report_q <= 1'b0;
								if (sts.req_bad) stat_q <= lob_pkg::ST_INVALID;
								else state_q <= S_MATCH;
							end
						end
					endcase
				end
				S_MATCH: if (sts.scan_last) state_q <= S_MDEC;
				S_MDEC: state_q <= sts.hit ? S_TRADE : S_FREE;
				S_TRADE: begin
					if (!report_q || sts.out_free) begin
						if (sts.fill_done) begin
							stat_q  <= lob_pkg::ST_COMPLETE;
							state_q <= S_BEST;
						end else begin
							state_q <= S_MATCH;
						end
					end
				end
				S_FREE: if (sts.scan_last) state_q <= S_REST;
				S_REST: begin
					if (!sts.hit) stat_q <= lob_pkg::ST_FULL;
					else if (sts.partial) stat_q <= lob_pkg::ST_PARTIAL;
					else stat_q <= lob_pkg::ST_SUCCESS;
					state_q <= S_BEST;
				end
				S_BEST: if (sts.scan_last) state_q <= S_STAT;
				S_STAT: if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/lob_dp.sv =====
`timescale 1ns / 1ps
module lob_dp #(
	parameter int unsigned MaxOrders = lob_pkg::MAX_ORDERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lob_pkg::cmd_t                 cmd,
	output lob_pkg::sts_t                 sts,
	input  logic signed [lob_pkg::DW-1:0] req_id,
	input  logic                          is_buy,
	input  logic signed [lob_pkg::DW-1:0] price,
	input  logic signed [lob_pkg::DW-1:0] volume,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_trade,
	output logic [2:0]                    status,
	output logic signed [lob_pkg::DW-1:0] taker_id,
	output logic signed [lob_pkg::DW-1:0] maker_id,
	output logic signed [lob_pkg::DW-1:0] trade_price,
	output logic [lob_pkg::TVW-1:0]       trade_qty,
	output logic                          taker_is_buy,
	output logic signed [lob_pkg::DW-1:0] bid_top,
	output logic signed [lob_pkg::DW-1:0] ask_top,
	output logic                          last
);

	localparam int unsigned IW = (MaxOrders > 1) ? $clog2(MaxOrders) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(MaxOrders - 1);

	// order table, one entry read per cycle at the scan index
	logic [MaxOrders-1:0]          ent_valid_q;
	logic signed [lob_pkg::DW-1:0] ent_id_q    [MaxOrders];
	logic                          ent_buy_q   [MaxOrders];
	logic signed [lob_pkg::DW-1:0] ent_price_q [MaxOrders];
	logic signed [lob_pkg::DW-1:0] ent_vol_q   [MaxOrders];
	logic [lob_pkg::DW-1:0]        ent_arr_q   [MaxOrders];
	logic [lob_pkg::DW-1:0]        arr_cnt_q;

	logic signed [lob_pkg::DW-1:0] req_id_q, req_price_q, req_vol_q, rem_q;
	logic                          req_buy_q;

	logic [IW-1:0]                 idx_q;
	logic                          acc_found_q, acc_buy_q;
	logic [IW-1:0]                 acc_idx_q;
	logic signed [lob_pkg::DW-1:0] acc_price_q, acc_id_q, acc_vol_q;
	logic [lob_pkg::DW-1:0]        acc_age_q;
	logic                          bid_found_q, ask_found_q;
	logic signed [lob_pkg::DW-1:0] bid_q, ask_q;

	logic                          e_valid, e_buy, elig, better, take;
	logic signed [lob_pkg::DW-1:0] e_id, e_price, e_vol, tv;
	logic [lob_pkg::DW-1:0]        e_age;

	assign e_valid = ent_valid_q[idx_q];
	assign e_buy   = ent_buy_q[idx_q];
	assign e_id    = ent_id_q[idx_q];
	assign e_price = ent_price_q[idx_q];
	assign e_vol   = ent_vol_q[idx_q];
	assign e_age   = arr_cnt_q - ent_arr_q[idx_q];

	assign tv = (rem_q < acc_vol_q) ? rem_q : acc_vol_q;

	always_comb begin
		elig   = e_valid && (e_buy != req_buy_q) &&
		         (req_buy_q ? (e_price <= req_price_q) : (e_price >= req_price_q));
		better = req_buy_q ? (e_price < acc_price_q) : (e_price > acc_price_q);
		case (cmd.mode)
			lob_pkg::SM_FIND:  take = !acc_found_q && e_valid && (e_id == req_id_q);
			lob_pkg::SM_MATCH: take = elig && (!acc_found_q || better ||
			                   (e_price == acc_price_q && e_age > acc_age_q));
			lob_pkg::SM_FREE:  take = !acc_found_q && !e_valid;
			default:           take = 1'b0;
		endcase
	end

	assign sts.scan_last = (idx_q == LAST_IDX);
	assign sts.hit       = acc_found_q;
	assign sts.shrink_ok = (req_price_q == acc_price_q) && (req_vol_q > 0) &&
	                       (req_vol_q < acc_vol_q);
	assign sts.req_bad   = (req_vol_q <= 0) || (req_price_q <= 0);
	assign sts.fill_done = (rem_q <= acc_vol_q);
	assign sts.partial   = (rem_q != req_vol_q);
	assign sts.out_free  = !out_valid || out_ready;

	// scan index and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			acc_found_q <= 1'b0;
			bid_found_q <= 1'b0;
			ask_found_q <= 1'b0;
		end else if (cmd.scan_start) begin
			idx_q       <= '0;
			acc_found_q <= 1'b0;
			bid_found_q <= 1'b0;
			ask_found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (idx_q != LAST_IDX) idx_q <= idx_q + 1'b1;
			if (take) acc_found_q <= 1'b1;
			if (cmd.mode == lob_pkg::SM_BEST && e_valid) begin
				if (e_buy && (!bid_found_q || e_price > bid_q)) bid_found_q <= 1'b1;
				if (!e_buy && (!ask_found_q || e_price < ask_q)) ask_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && take) begin
			acc_idx_q   <= idx_q;
			acc_price_q <= e_price;
			acc_age_q   <= e_age;
			acc_id_q    <= e_id;
			acc_vol_q   <= e_vol;
			acc_buy_q   <= e_buy;
		end
		if (cmd.scan_step && cmd.mode == lob_pkg::SM_BEST && e_valid) begin
			if (e_buy && (!bid_found_q || e_price > bid_q)) bid_q <= e_price;
			if (!e_buy && (!ask_found_q || e_price < ask_q)) ask_q <= e_price;
		end
		if (cmd.load) begin
			req_id_q    <= req_id;
			req_buy_q   <= is_buy;
			req_price_q <= price;
			req_vol_q   <= volume;
			rem_q       <= volume;
		end
		if (cmd.side_from_hit) req_buy_q <= acc_buy_q;
		if (cmd.do_trade) rem_q <= rem_q - tv;
	end

	// table writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			arr_cnt_q   <= '0;
		end else begin
			if (cmd.kill) ent_valid_q[acc_idx_q] <= 1'b0;
			if (cmd.do_trade && tv == acc_vol_q) ent_valid_q[acc_idx_q] <= 1'b0;
			if (cmd.rest) begin
				ent_valid_q[acc_idx_q] <= 1'b1;
				arr_cnt_q <= arr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shrink) ent_vol_q[acc_idx_q] <= req_vol_q;
		if (cmd.do_trade) ent_vol_q[acc_idx_q] <= acc_vol_q - tv;
		if (cmd.rest) begin
			ent_id_q[acc_idx_q]    <= req_id_q;
			ent_buy_q[acc_idx_q]   <= req_buy_q;
			ent_price_q[acc_idx_q] <= req_price_q;
			ent_vol_q[acc_idx_q]   <= rem_q;
			ent_arr_q[acc_idx_q]   <= arr_cnt_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_trade || cmd.emit_status) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_trade) begin
			is_trade     <= 1'b1;
			status       <= lob_pkg::ST_SUCCESS;
			taker_id     <= req_id_q;
			maker_id     <= acc_id_q;
			trade_price  <= acc_price_q;
			trade_qty    <= tv[lob_pkg::TVW-1:0];
			taker_is_buy <= req_buy_q;
			bid_top      <= '0;
			ask_top      <= '0;
			last         <= 1'b0;
		end else if (cmd.emit_status) begin
			is_trade     <= 1'b0;
			status       <= cmd.stat;
			taker_id     <= req_id_q;
			maker_id     <= '0;
			trade_price  <= '0;
			trade_qty    <= '0;
			taker_is_buy <= 1'b0;
			bid_top      <= bid_found_q ? bid_q : '0;
			ask_top      <= ask_found_q ? ask_q : '0;
			last         <= 1'b1;
		end
	end

endmodule

// ===== hw/rtl/limit_order_book_matcher_top.sv =====
// From acceptance to the status item: a check step, the table scans, then the status register.
// Unknown type or invalid place: the best bid/ask scan only. Cancel, duplicate, not found,
// shrink, invalid modify: a find scan, then the best bid/ask scan. A place or re-place adds
// match scans until filled or no maker is left, then a free-slot scan for leftover volume.
// Throughput: one request at a time, next item taken once the status is registered; a stalled
// output holds the trade and status steps. Reset: arst_n async, active low; empties the book.
`timescale 1ns / 1ps
module limit_order_book_matcher_top #(
	parameter int unsigned MaxOrders = lob_pkg::MAX_ORDERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic signed [lob_pkg::DW-1:0] req_id,
	input  logic                          is_buy,
	input  logic signed [lob_pkg::DW-1:0] price,
	input  logic signed [lob_pkg::DW-1:0] volume,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_trade,
	output logic [2:0]                    status,
	output logic signed [lob_pkg::DW-1:0] taker_id,
	output logic signed [lob_pkg::DW-1:0] maker_id,
	output logic signed [lob_pkg::DW-1:0] trade_price,
	output logic [lob_pkg::TVW-1:0]       trade_qty,
	output logic                          taker_is_buy,
	output logic signed [lob_pkg::DW-1:0] bid_top,
	output logic signed [lob_pkg::DW-1:0] ask_top,
	output logic                          last
);

	// Controller sequences table scans (find id, best match, free slot,
	// best bid/ask); datapath holds the book and the output register.
	lob_pkg::cmd_t cmd;
	lob_pkg::sts_t sts;

	lob_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	lob_dp #(
		.MaxOrders (MaxOrders)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_id       (req_id),
		.is_buy       (is_buy),
		.price        (price),
		.volume       (volume),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_trade     (is_trade),
		.status       (status),
		.taker_id     (taker_id),
		.maker_id     (maker_id),
		.trade_price  (trade_price),
		.trade_qty    (trade_qty),
		.taker_is_buy (taker_is_buy),
		.bid_top      (bid_top),
		.ask_top      (ask_top),
		.last         (last)
	);

	// a trade item never closes a request
	a_trade_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_trade && last))
		else $error("trade item flagged last");

	// trade items carry a zero status
	a_trade_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_trade) |-> (status == lob_pkg::ST_SUCCESS))
		else $error("trade item with nonzero status");

	// in_ready is low in the cycle after an item is accepted
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready straight after accept");

endmodule
